// ----- rtl/core/lfu_pkg.sv -----
`default_nettype none
package lfu_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  localparam int USES_W   = 16;
  localparam int STAMP_W  = 32;
  localparam int FAULT_W  = 32;
  localparam int CFG_W    = 4;
  localparam int SLOT_W   = 3;
  localparam int EVPAGE_W = 16;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  localparam int OUT_FIELD_W = 1 + SLOT_W + 1 + EVPAGE_W + FAULT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear_valid;
  } fs_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/lfu_frame_store.sv -----
`default_nettype none
module lfu_frame_store #(
  parameter int FRAMES  = lfu_pkg::FRAMES_DEF,
  parameter int ENTRY_W = lfu_pkg::PAGE_BITS_DEF + lfu_pkg::USES_W + lfu_pkg::STAMP_W,
  parameter int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lfu_pkg::fs_ctrl_t    ctrl,
  input  wire logic [IDX_W-1:0]     rd_addr,
  input  wire logic [IDX_W-1:0]     wr_addr,
  input  wire logic [ENTRY_W-1:0]   wr_data,
  output logic      [ENTRY_W-1:0]   rd_data,
  output logic      [FRAMES-1:0]    valid
);

  logic [ENTRY_W-1:0] mem [FRAMES];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [FRAMES-1:0]  valid_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear_valid) begin
      valid_r <= '0;
    end else if (ctrl.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;
  assign valid   = valid_r;

endmodule
`default_nettype wire

// ----- rtl/core/lfu_page_replacement.sv -----
// LFU page replacement engine.
// in_*   : one page reference per request; in_tdata carries the page number,
//          in_tlast marks the last reference of a run.
// out_*  : one result per reference (hit, slot, evicted page, fault count),
//          out_tlast echoes in_tlast.
// cfg_*  : APB register 0 (byte address 0) holds frames_in_use, 4 bits.
// Frame contents live in a single-port-read, single-port-write memory with
// a registered read port; per-frame valid flags are flops.
// Each reference sweeps the n active frames (n = clamped frames_in_use),
// one memory read per cycle, tracking the first match, the first empty frame
// and the least used / oldest frame, then writes back one entry.
// A new reference is accepted only in the idle state, once the previous one
// has been written back, so references are taken one at a time, bound by the sweep.
// The result sits in an output register, so the next reference is accepted
// while it waits; a stalled receiver holds the engine only at write-back.
// Reset clears all frames, the reference counter, the fault count and the
// output register, and sets frames_in_use to 8. A last reference clears the
// frames and counters after its result; the register keeps its value.
`default_nettype none
module lfu_page_replacement #(
  parameter int FRAMES    = lfu_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lfu_pkg::PAGE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // [PAGE_BITS-1:0] page_number, rest zero
  input  wire logic [((PAGE_BITS+7)/8)*8-1:0]   in_tdata,
  input  wire logic                             in_tlast,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [0] hit, [3:1] slot, [4] evicted_valid, [20:5] evicted_page,
  // [52:21] fault_count, rest zero
  output logic [lfu_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [lfu_pkg::APB_AW-1:0]       cfg_paddr,
  input  wire logic [lfu_pkg::APB_DW-1:0]       cfg_pwdata,
  output logic [lfu_pkg::APB_DW-1:0]            cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int USES_W  = lfu_pkg::USES_W;
  localparam int STAMP_W = lfu_pkg::STAMP_W;
  localparam int ENTRY_W = PAGE_BITS + USES_W + STAMP_W;
  localparam int CFG_W   = lfu_pkg::CFG_W;

  lfu_pkg::state_t state_r, state_nxt;
  lfu_pkg::fs_ctrl_t fs_ctrl;

  logic [CFG_W-1:0]        cfg_r;
  logic [PAGE_BITS-1:0]    page_r;
  logic                    last_r;
  logic [IDX_W-1:0]        last_idx_r;
  logic [IDX_W-1:0]        cmp_idx_r;
  logic                    found_r;
  logic [IDX_W-1:0]        hit_idx_r;
  logic [USES_W-1:0]       hit_uses_r;
  logic [STAMP_W-1:0]      hit_stamp_r;
  logic                    empty_r;
  logic [IDX_W-1:0]        empty_idx_r;
  logic [IDX_W-1:0]        min_idx_r;
  logic [USES_W-1:0]       min_uses_r;
  logic [STAMP_W-1:0]      min_stamp_r;
  logic [PAGE_BITS-1:0]    min_page_r;
  logic [STAMP_W-1:0]      ref_cnt_r;
  logic [lfu_pkg::FAULT_W-1:0] faults_r;

  logic                    out_valid_r;
  logic                    out_last_r;
  logic                    out_hit_r;
  logic [lfu_pkg::SLOT_W-1:0]   out_slot_r;
  logic                    out_evv_r;
  logic [lfu_pkg::EVPAGE_W-1:0] out_evp_r;
  logic [lfu_pkg::FAULT_W-1:0]  out_fault_r;

  logic                    in_acc;
  logic                    out_free;
  logic                    commit;
  logic [31:0]             act_frames;
  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W-1:0]        sel_idx;
  logic [ENTRY_W-1:0]      wr_data;
  logic [ENTRY_W-1:0]      rd_data;
  logic [FRAMES-1:0]       valid;
  logic [PAGE_BITS-1:0]    e_page;
  logic [USES_W-1:0]       e_uses;
  logic [STAMP_W-1:0]      e_stamp;
  logic                    e_valid;
  logic                    take_min;
  logic [USES_W-1:0]       uses_inc;
  logic [lfu_pkg::FAULT_W-1:0] faults_inc;
  logic                    scan_done;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lfu_pkg::CFG_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      cfg_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(lfu_pkg::APB_DW-CFG_W){1'b0}}, cfg_r};

  always_comb begin
    if (cfg_r == '0) begin
      act_frames = 32'd1;
    end else if (32'(cfg_r) > 32'(FRAMES)) begin
      act_frames = 32'(FRAMES);
    end else begin
      act_frames = 32'(cfg_r);
    end
  end

  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign scan_done = (cmp_idx_r == last_idx_r);

  assign e_page  = rd_data[PAGE_BITS-1:0];
  assign e_uses  = rd_data[PAGE_BITS +: USES_W];
  assign e_stamp = rd_data[PAGE_BITS+USES_W +: STAMP_W];
  assign e_valid = valid[cmp_idx_r];
  assign take_min = (cmp_idx_r == '0) || (e_uses < min_uses_r) ||
                    ((e_uses == min_uses_r) && (e_stamp < min_stamp_r));

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    fs_ctrl   = '0;
    rd_addr   = '0;
    commit    = 1'b0;
    unique case (state_r)
      lfu_pkg::ST_IDLE: begin
        in_tready     = 1'b1;
        fs_ctrl.rd_en = in_tvalid;
        if (in_tvalid) begin
          state_nxt = lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        rd_addr       = cmp_idx_r + IDX_W'(1);
        fs_ctrl.rd_en = !scan_done;
        if (scan_done) begin
          state_nxt = lfu_pkg::ST_WRITE;
        end
      end
      lfu_pkg::ST_WRITE: begin
        if (out_free) begin
          commit              = 1'b1;
          fs_ctrl.wr_en       = 1'b1;
          fs_ctrl.clear_valid = last_r;
          state_nxt           = lfu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  // sweep bookkeeping
  always_ff @(posedge clk) begin
    if (in_acc) begin
      page_r     <= in_tdata[PAGE_BITS-1:0];
      last_r     <= in_tlast;
      last_idx_r <= IDX_W'(act_frames - 32'd1);
      cmp_idx_r  <= '0;
      found_r    <= 1'b0;
      empty_r    <= 1'b0;
    end else if (state_r == lfu_pkg::ST_SCAN) begin
      if (!scan_done) begin
        cmp_idx_r <= cmp_idx_r + IDX_W'(1);
      end
      if (!found_r && e_valid && (e_page == page_r)) begin
        found_r     <= 1'b1;
        hit_idx_r   <= cmp_idx_r;
        hit_uses_r  <= e_uses;
        hit_stamp_r <= e_stamp;
      end
      if (!empty_r && !e_valid) begin
        empty_r     <= 1'b1;
        empty_idx_r <= cmp_idx_r;
      end
      if (take_min) begin
        min_idx_r   <= cmp_idx_r;
        min_uses_r  <= e_uses;
        min_stamp_r <= e_stamp;
        min_page_r  <= e_page;
      end
    end
  end

  assign sel_idx    = found_r ? hit_idx_r : (empty_r ? empty_idx_r : min_idx_r);
  assign uses_inc   = (hit_uses_r == '1) ? hit_uses_r : hit_uses_r + USES_W'(1);
  assign faults_inc = (faults_r == '1) ? faults_r : faults_r + lfu_pkg::FAULT_W'(1);
  assign wr_data    = found_r ? {hit_stamp_r, uses_inc, page_r}
                              : {ref_cnt_r, USES_W'(1), page_r};

  // run counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_cnt_r <= '0;
      faults_r  <= '0;
    end else if (commit) begin
      if (last_r) begin
        ref_cnt_r <= '0;
        faults_r  <= '0;
      end else begin
        if (ref_cnt_r != '1) begin
          ref_cnt_r <= ref_cnt_r + STAMP_W'(1);
        end
        if (!found_r) begin
          faults_r <= faults_inc;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r   <= found_r;
      out_slot_r  <= lfu_pkg::SLOT_W'(sel_idx);
      out_evv_r   <= !found_r && !empty_r;
      out_evp_r   <= (!found_r && !empty_r) ? lfu_pkg::EVPAGE_W'(min_page_r) : '0;
      out_fault_r <= found_r ? faults_r : faults_inc;
      out_last_r  <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(lfu_pkg::OUT_TDATA_W-lfu_pkg::OUT_FIELD_W){1'b0}},
                       out_fault_r, out_evp_r, out_evv_r, out_slot_r, out_hit_r};

  lfu_frame_store #(
    .FRAMES  (FRAMES),
    .ENTRY_W (ENTRY_W),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (fs_ctrl),
    .rd_addr (rd_addr),
    .wr_addr (sel_idx),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .valid   (valid)
  );

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == lfu_pkg::ST_SCAN))
    else $error("accepted request did not start a sweep");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lfu_pkg::ST_SCAN) |-> (cmp_idx_r <= last_idx_r))
    else $error("sweep index past active frames");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("write-back without result");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> !out_evv_r)
    else $error("hit reported an eviction");

  a_evict_counts_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_evv_r) |-> (out_fault_r != '0))
    else $error("eviction with zero fault count");

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lfu_pkg::*;

  localparam int                PAGE_W             = PAGE_BITS_DEF;
  localparam int                PAD_W              = OUT_TDATA_W - OUT_FIELD_W;
  localparam int                REG_FRAMES_IN_USE  = 0;
  localparam logic [APB_AW-1:0] ADDR_FRAMES_IN_USE = APB_AW'(4 * REG_FRAMES_IN_USE);
  localparam int                SETTLE_CYCLES      = 24;
  localparam int                HOLD_CYCLES        = 400;
  localparam int                PHASES             = 8;
  localparam int                PHASE_REFS         = 200;
  localparam logic [USES_W-1:0] USES_SAT           = '1;

  typedef struct packed {
    logic                 last;
    logic [PAD_W-1:0]     pad;
    logic [FAULT_W-1:0]   faults;
    logic [EVPAGE_W-1:0]  ev_page;
    logic                 ev_valid;
    logic [SLOT_W-1:0]    slot;
    logic                 hit;
  } lfu_result_t;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [PAGE_W-1:0]   value;
    logic                last;
    logic                typed;
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [FAULT_W-1:0]  faults;
  } plan_row_t;

  plan_row_t directed_plan [25] = '{
    '{ROW_REF, 16'h0000, 1'b0, 1'b1, 1'b0, 3'd0, 32'd1},
    '{ROW_REF, 16'hFFFF, 1'b0, 1'b1, 1'b0, 3'd1, 32'd2},
    '{ROW_REF, 16'h0000, 1'b0, 1'b1, 1'b1, 3'd0, 32'd2},
    '{ROW_REF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 3'd1, 32'd2},
    '{ROW_CFG, 16'd2,    1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_REF, 16'h1234, 1'b0, 1'b1, 1'b0, 3'd0, 32'd1},
    '{ROW_REF, 16'h5678, 1'b0, 1'b1, 1'b0, 3'd1, 32'd2},
    '{ROW_REF, 16'h1234, 1'b0, 1'b1, 1'b1, 3'd0, 32'd2},
    '{ROW_REF, 16'h9ABC, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_REF, 16'h0F0F, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_REF, 16'h0F0F, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_REF, 16'hAAAA, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_CFG, 16'd1,    1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_REF, 16'h0F0F, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_CFG, 16'd2,    1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_REF, 16'h0F0F, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_CFG, 16'd0,    1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_REF, 16'h5555, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_REF, 16'h5555, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_CFG, 16'd15,   1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_REF, 16'h8000, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_REF, 16'h0001, 1'b1, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_CFG, 16'd8,    1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
    '{ROW_REF, 16'h0001, 1'b0, 1'b1, 1'b0, 3'd0, 32'd1},
    '{ROW_REF, 16'h0001, 1'b1, 1'b1, 1'b1, 3'd0, 32'd1}
  };

  localparam logic [CFG_W-1:0] PHASE_FRAMES [PHASES] = '{8, 3, 1, 15, 0, 5, 2, 8};
  localparam int SEND_IDLE [PHASES] = '{0, 56, 0, 25, 0, 56, 0, 25};
  localparam int RECV_STALL [PHASES] = '{0, 0, 56, 25, 0, 0, 56, 25};

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic [PAGE_W-1:0]       in_tdata    = '0;
  logic                    in_tlast    = 1'b0;
  logic                    in_tvalid   = 1'b0;
  logic                    in_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tlast;
  logic                    out_tvalid;
  logic                    out_tready  = 1'b0;
  logic                    cfg_psel    = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite  = 1'b0;
  logic [APB_AW-1:0]       cfg_paddr   = '0;
  logic [APB_DW-1:0]       cfg_pwdata  = '0;
  logic [APB_DW-1:0]       cfg_prdata;
  logic                    cfg_pready;

  // predictor state
  logic                    fr_valid [FRAMES_DEF] = '{default: 1'b0};
  logic [PAGE_W-1:0]       fr_page  [FRAMES_DEF] = '{default: '0};
  logic [USES_W-1:0]       fr_uses  [FRAMES_DEF] = '{default: '0};
  logic [STAMP_W-1:0]      fr_stamp [FRAMES_DEF] = '{default: '0};
  logic [STAMP_W-1:0]      ref_count   = '0;
  logic [FAULT_W-1:0]      fault_total = '0;
  logic [CFG_W-1:0]        frames_cfg  = CFG_RESET;

  lfu_result_t             expected_results [$];
  int                      errors        = 0;
  int                      send_idle_pct = 0;
  int                      stall_pct     = 0;
  logic                    hold_active   = 1'b0;
  event                    hold_kick;

  lfu_page_replacement dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),    // [15:0] page_number
    .in_tlast    (in_tlast),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),   // hit, slot[3], evicted_valid, evicted_page[16], fault_count[32]
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic flag(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic lfu_result_t predict_ref(input logic [PAGE_W-1:0] page, input logic last);
    lfu_result_t r;
    int          n;
    int          sel;
    int          k;
    bit          found;
    bit          empty;
    r     = '0;
    sel   = 0;
    found = 1'b0;
    empty = 1'b0;
    n     = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES_DEF) ? FRAMES_DEF : int'(frames_cfg);
    for (k = 0; k < n; k++) begin
      if (!found && fr_valid[k] && fr_page[k] == page) begin
        sel   = k;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (fr_uses[sel] != USES_SAT) fr_uses[sel] = fr_uses[sel] + 1'b1;
    end else begin
      for (k = 0; k < n; k++) begin
        if (!empty && !fr_valid[k]) begin
          sel   = k;
          empty = 1'b1;
        end
      end
      if (!empty) begin
        sel = 0;
        for (k = 1; k < n; k++) begin
          if (fr_uses[k] < fr_uses[sel] ||
              (fr_uses[k] == fr_uses[sel] && fr_stamp[k] < fr_stamp[sel])) sel = k;
        end
        r.ev_valid = 1'b1;
        r.ev_page  = fr_page[sel];
      end
      fr_valid[sel] = 1'b1;
      fr_page[sel]  = page;
      fr_uses[sel]  = 1;
      fr_stamp[sel] = ref_count;
      if (fault_total != '1) fault_total = fault_total + 1'b1;
    end
    if (ref_count != '1) ref_count = ref_count + 1'b1;
    r.slot   = SLOT_W'(sel);
    r.faults = fault_total;
    r.last   = last;
    if (last) begin
      for (k = 0; k < FRAMES_DEF; k++) begin
        fr_valid[k] = 1'b0;
        fr_page[k]  = '0;
        fr_uses[k]  = '0;
        fr_stamp[k] = '0;
      end
      ref_count   = '0;
      fault_total = '0;
    end
    return r;
  endfunction

  task automatic drive_ref(input logic [PAGE_W-1:0] page, input logic last,
                           input logic typed, input lfu_result_t typed_exp);
    lfu_result_t predicted;
    while (chance(send_idle_pct)) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= page;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predicted = predict_ref(page, last);
    expected_results.push_back(typed ? typed_exp : predicted);
    @(negedge clk);
  endtask

  // drop valid, wait for every outstanding request to come back, then let the engine settle
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_FRAMES_IN_USE;
    cfg_pwdata  <= APB_DW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    frames_cfg = value;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== APB_DW'(value))
      flag($sformatf("frames_in_use read %h, wrote %h", cfg_prdata, value));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic run_random(input int n_refs);
    logic [PAGE_W-1:0] pool [12];
    int                pool_n;
    int                run_left;
    int                k;
    int                roll;
    logic [PAGE_W-1:0] page;
    logic              last;
    pool_n   = 2;
    run_left = 0;
    for (k = 0; k < n_refs; k++) begin
      if (run_left == 0) begin
        pool_n = $urandom_range(12, 2);
        foreach (pool[j]) pool[j] = PAGE_W'($urandom);
        run_left = $urandom_range(80, 4);
      end
      roll = $urandom_range(99);
      if (roll < 10) page = PAGE_W'($urandom);
      else if (roll < 55) page = pool[$urandom_range(2)];
      else page = pool[$urandom_range(pool_n - 1)];
      run_left--;
      last = (run_left == 0) || chance(1);
      drive_ref(page, last, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    lfu_result_t got;
    lfu_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tlast, out_tdata};
      if (expected_results.size() == 0) begin
        flag($sformatf("result with no request pending: %h", got));
      end else begin
        want = expected_results.pop_front();
        if (got !== want)
          flag($sformatf({"exp hit=%0b slot=%0d ev=%0b/%h faults=%0d last=%0b pad=%h, ",
                          "got hit=%0b slot=%0d ev=%0b/%h faults=%0d last=%0b pad=%h"},
                         want.hit, want.slot, want.ev_valid, want.ev_page, want.faults,
                         want.last, want.pad, got.hit, got.slot, got.ev_valid, got.ev_page,
                         got.faults, got.last, got.pad));
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= !(hold_active || chance(stall_pct));
  end

  initial begin
    forever begin
      @(hold_kick);
      @(posedge clk);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    lfu_result_t typed_exp;
    int          p;
    repeat (11) @(negedge clk);
    rst_n         <= 1'b1;
    send_idle_pct = 25;
    stall_pct     = 25;
    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_CFG) begin
        settle();
        write_cfg(CFG_W'(directed_plan[r].value));
      end else begin
        typed_exp          = '0;
        typed_exp.hit      = directed_plan[r].hit;
        typed_exp.slot     = directed_plan[r].slot;
        typed_exp.faults   = directed_plan[r].faults;
        typed_exp.last     = directed_plan[r].last;
        drive_ref(directed_plan[r].value, directed_plan[r].last,
                  directed_plan[r].typed, typed_exp);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      settle();
      write_cfg(PHASE_FRAMES[p]);
      send_idle_pct = SEND_IDLE[p];
      stall_pct     = RECV_STALL[p];
      if (p == 0) -> hold_kick;
      run_random(PHASE_REFS);
    end
    settle();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
